// ----- rtl/bls_pkg.sv -----
// Shared constants, register codes and record types for the line pixel stepper.
`default_nettype none

package bls_pkg;

   localparam int COORD_W     = 16;
   localparam int WIN_W       = 14;
   localparam int BPP_W       = 7;
   localparam int STRIDE_W    = 16;
   localparam int COLOR_W     = 32;
   localparam int OFFSET_W    = 32;
   localparam int PCT_W       = 7;
   localparam int ACTION_W    = 1;

   localparam int DELTA_W     = COORD_W + 1;
   localparam int ERR_W       = COORD_W + 3;
   localparam int COUNT_W     = COORD_W + 1;
   localparam int CMP_W       = ((COORD_W > WIN_W) ? COORD_W : WIN_W) + 1;
   localparam int NUM_W       = COUNT_W + PCT_W;
   localparam int BIT_W       = $clog2(PCT_W);
   localparam int BYTE_STEP_W = BPP_W - 3;

   localparam int PCT_SCALE   = 100;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_PIXEL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_STRIDE    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH   = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_HEIGHT  = CSR_INDEX_W'(3);

   localparam logic [BPP_W-1:0]    RESET_BITS_PER_PIXEL = BPP_W'(32);
   localparam logic [STRIDE_W-1:0] RESET_LINE_STRIDE    = STRIDE_W'(7680);
   localparam logic [WIN_W-1:0]    RESET_WINDOW_WIDTH   = WIN_W'(1920);
   localparam logic [WIN_W-1:0]    RESET_WINDOW_HEIGHT  = WIN_W'(1080);

   localparam logic [ACTION_W-1:0] ACTION_START = 1'b0;
   localparam logic [ACTION_W-1:0] ACTION_STEP  = 1'b1;

   typedef struct packed {
      logic [BPP_W-1:0]    bits_per_pixel;
      logic [STRIDE_W-1:0] line_stride;
      logic [WIN_W-1:0]    window_width;
      logic [WIN_W-1:0]    window_height;
   } bls_cfg_type;

   // One pixel of the walk as handed from the stepper to the output side.
   typedef struct packed {
      logic [WIN_W-1:0]   x;
      logic [WIN_W-1:0]   y;
      logic               visible;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] major;
      logic [COLOR_W-1:0] first_color;
      logic [COLOR_W-1:0] second_color;
      logic               gradient;
      logic               last;
   } bls_pixel_type;

endpackage

`default_nettype wire

// ----- rtl/bls_req_if.sv -----
// Input channel: start and step items.
`default_nettype none

interface bls_req_if;
   import bls_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic [COLOR_W-1:0]        start_color;
   logic [COLOR_W-1:0]        end_color;

   modport source (output valid, action, start_x, start_y, end_x, end_y,
                   start_color, end_color, input ready);
   modport sink (input valid, action, start_x, start_y, end_x, end_y,
                 start_color, end_color, output ready);
endinterface

`default_nettype wire

// ----- rtl/bls_rsp_if.sv -----
// Result channel: one record per stepped pixel, visible or not.
`default_nettype none

interface bls_rsp_if;
   import bls_pkg::*;

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] pixel_offset;
   logic                visible;
   logic [COLOR_W-1:0]  first_color;
   logic [COLOR_W-1:0]  second_color;
   logic                gradient_mode;
   logic [PCT_W-1:0]    gradient_percent;
   logic                last;

   modport source (output valid, pixel_offset, visible, first_color, second_color,
                   gradient_mode, gradient_percent, last, input ready);
   modport sink (input valid, pixel_offset, visible, first_color, second_color,
                 gradient_mode, gradient_percent, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/bls_csr_if.sv -----
// Register write channel.
`default_nettype none

interface bls_csr_if;
   import bls_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bls_front.sv -----
// Line setup and Bresenham stepping; one pixel record per step item while a line is active.
`default_nettype none

module bls_front (
   input  logic                  clock,
   input  logic                  reset,
   input  bls_pkg::bls_cfg_type  cfg,
   bls_req_if.sink               req_ch,
   output logic                  push,
   output bls_pkg::bls_pixel_type push_data,
   input  logic                  full
);
   import bls_pkg::*;

   logic                      active_ff, active_in;
   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_W-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [DELTA_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [COUNT_W-1:0]        count_ff, count_in, major_ff, major_in;
   logic [COLOR_W-1:0]        color_a_ff, color_a_in, color_b_ff, color_b_in;

   logic                      accept;
   logic signed [DELTA_W-1:0] sx_w, sy_w, ex_w, ey_w, diff_x, diff_y;
   logic [DELTA_W-1:0]        new_dx, new_dy, new_max;
   logic signed [CMP_W-1:0]   sx_c, sy_c, cx, cy, wx, hy;
   logic                      start_ok;
   logic signed [ERR_W-1:0]   new_err, dxs, dys;
   logic                      vis, fin, move_x, move_y;

   assign req_ch.ready = !full;
   assign accept = req_ch.valid && req_ch.ready;

   assign wx = signed'(CMP_W'(cfg.window_width));
   assign hy = signed'(CMP_W'(cfg.window_height));

   // Line setup.
   always_comb begin
      sx_w = DELTA_W'(req_ch.start_x);
      sy_w = DELTA_W'(req_ch.start_y);
      ex_w = DELTA_W'(req_ch.end_x);
      ey_w = DELTA_W'(req_ch.end_y);
      diff_x = ex_w - sx_w;
      diff_y = ey_w - sy_w;
      new_dx = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
      new_dy = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
      sx_c = CMP_W'(req_ch.start_x);
      sy_c = CMP_W'(req_ch.start_y);
      start_ok = (!req_ch.start_x[COORD_W-1] && (sx_c < wx)) ||
                 (!req_ch.start_y[COORD_W-1] && (sy_c < hy));
      if (new_dx > new_dy) begin
         new_err = signed'(ERR_W'(new_dx >> 1));
         new_max = new_dx;
      end else begin
         new_err = -signed'(ERR_W'(new_dy >> 1));
         new_max = new_dy;
      end
   end

   // Current pixel classification and the next Bresenham move.
   always_comb begin
      cx = CMP_W'(cur_x_ff);
      cy = CMP_W'(cur_y_ff);
      vis = (cx > 0) && (cx < wx) && (cy > 0) && (cy < hy);
      fin = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
      dxs = signed'(ERR_W'(dx_ff));
      dys = signed'(ERR_W'(dy_ff));
      move_x = err_ff > -dxs;
      move_y = err_ff < dys;
   end

   assign push = accept && (req_ch.action == ACTION_STEP) && active_ff;

   always_comb begin
      push_data.x            = vis ? cx[WIN_W-1:0] : '0;
      push_data.y            = vis ? cy[WIN_W-1:0] : '0;
      push_data.visible      = vis;
      push_data.count        = count_ff;
      push_data.major        = major_ff;
      push_data.first_color  = color_a_ff;
      push_data.second_color = color_b_ff;
      push_data.gradient     = color_a_ff != color_b_ff;
      push_data.last         = fin;
   end

   always_comb begin
      active_in  = active_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      err_in     = err_ff;
      count_in   = count_ff;
      major_in   = major_ff;
      color_a_in = color_a_ff;
      color_b_in = color_b_ff;
      if (accept && (req_ch.action == ACTION_START)) begin
         active_in  = start_ok;
         cur_x_in   = req_ch.start_x;
         cur_y_in   = req_ch.start_y;
         tgt_x_in   = req_ch.end_x;
         tgt_y_in   = req_ch.end_y;
         dx_in      = new_dx;
         dy_in      = new_dy;
         neg_x_in   = !(req_ch.start_x < req_ch.end_x);
         neg_y_in   = !(req_ch.start_y < req_ch.end_y);
         err_in     = new_err;
         count_in   = '0;
         major_in   = (new_max == '0) ? COUNT_W'(1) : COUNT_W'(new_max);
         color_a_in = req_ch.start_color;
         color_b_in = req_ch.end_color;
      end else if (push) begin
         if (vis) begin
            count_in = COUNT_W'(count_ff + 1'b1);
         end
         if (fin) begin
            active_in = 1'b0;
         end else begin
            err_in = err_ff - (move_x ? dys : '0) + (move_y ? dxs : '0);
            if (move_x) begin
               cur_x_in = neg_x_ff ? COORD_W'(cur_x_ff - 1'b1) : COORD_W'(cur_x_ff + 1'b1);
            end
            if (move_y) begin
               cur_y_in = neg_y_ff ? COORD_W'(cur_y_ff - 1'b1) : COORD_W'(cur_y_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      tgt_x_ff   <= tgt_x_in;
      tgt_y_ff   <= tgt_y_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      err_ff     <= err_in;
      count_ff   <= count_in;
      major_ff   <= major_in;
      color_a_ff <= color_a_in;
      color_b_ff <= color_b_in;
   end

endmodule

`default_nettype wire

// ----- rtl/bls_fifo.sv -----
// Short pixel queue between the stepper and the output side.
`default_nettype none

module bls_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bls_pkg::bls_pixel_type push_data,
   output logic                   full,
   input  logic                   pop,
   output bls_pkg::bls_pixel_type pop_data,
   output logic                   empty
);
   import bls_pkg::*;

   bls_pixel_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   assign full     = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = QCNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = QCNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("pixel queue written while full");

endmodule

`default_nettype wire

// ----- rtl/bls_back.sv -----
// Output side: byte offset, gradient percent by shift-subtract division, result register.
`default_nettype none

module bls_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bls_pkg::bls_cfg_type   cfg,
   input  logic                   empty,
   input  bls_pkg::bls_pixel_type pop_data,
   output logic                   pop,
   bls_rsp_if.source              rsp_ch
);
   import bls_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   bls_pixel_type         rec_ff, rec_in;
   logic [OFFSET_W-1:0]   off_ff, off_in;
   logic [NUM_W-1:0]      rem_ff, rem_in;
   logic [COUNT_W-1:0]    den_ff, den_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [PCT_W-1:0]      quo_ff, quo_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   bls_pixel_type         rsp_rec_ff, rsp_rec_in;
   logic [OFFSET_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [PCT_W-1:0]      rsp_pct_ff, rsp_pct_in;

   logic [BYTE_STEP_W+WIN_W-1:0] prod_x;
   logic [STRIDE_W+WIN_W-1:0]    prod_y;
   logic [NUM_W-1:0]             trial;
   logic                         slot_free;

   assign pop       = (state_ff == ST_IDLE) && !empty;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      prod_x = cfg.bits_per_pixel[BPP_W-1:3] * rec_ff.x;
      prod_y = cfg.line_stride * rec_ff.y;
      trial  = NUM_W'(den_ff) << bit_ff;
   end

   always_comb begin
      state_in     = state_ff;
      rec_in       = rec_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_rec_in   = rsp_rec_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_pct_in   = rsp_pct_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               rec_in   = pop_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            off_in = OFFSET_W'(prod_x) + OFFSET_W'(prod_y);
            rem_in = NUM_W'(rec_ff.count) * NUM_W'(PCT_SCALE);
            den_in = rec_ff.major;
            bit_in = BIT_W'(PCT_W - 1);
            quo_in = '0;
            state_in = (rec_ff.visible && rec_ff.gradient) ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            // The quotient never exceeds 100, so seven restoring steps cover it.
            if (rem_ff >= trial) begin
               rem_in         = rem_ff - trial;
               quo_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in = BIT_W'(bit_ff - 1'b1);
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = rec_ff;
               rsp_off_in   = rec_ff.visible ? off_ff : '0;
               rsp_pct_in   = quo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rec_ff     <= rec_in;
      off_ff     <= off_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      bit_ff     <= bit_in;
      quo_ff     <= quo_in;
      rsp_rec_ff <= rsp_rec_in;
      rsp_off_ff <= rsp_off_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.pixel_offset     = rsp_off_ff;
   assign rsp_ch.visible          = rsp_rec_ff.visible;
   assign rsp_ch.first_color      = rsp_rec_ff.first_color;
   assign rsp_ch.second_color     = rsp_rec_ff.second_color;
   assign rsp_ch.gradient_mode    = rsp_rec_ff.gradient;
   assign rsp_ch.gradient_percent = rsp_pct_ff;
   assign rsp_ch.last             = rsp_rec_ff.last;

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= PCT_W'(PCT_SCALE)))
      else $error("gradient percent above full scale");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rec_ff.visible) |-> (rsp_off_ff == '0 && rsp_pct_ff == '0))
      else $error("hidden pixel carries offset or percent");

   a_div_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("percent division with zero divisor");

endmodule

`default_nettype wire

// ----- rtl/bresenham_line_pixel_stepper.sv -----
// Top level of the Bresenham line pixel stepper.
// A start item (action 0) sets up a line and produces no result; a step item (action 1)
// is taken while the queue has room and, if a line is active, makes the stepper walk one
// step and queue one pixel record in a two-entry queue. The output side handles one pixel
// at a time through its idle, multiply and output states, with a divide state between
// when the pixel is visible and the colors differ, because the gradient percent comes
// from a shift-subtract divider that resolves one quotient bit per cycle over seven bits.
// Results wait in an output register, so the stepper keeps taking items while a result
// is held and the queue has room. Registers are written through the csr channel, which is
// always ready, only while the block is idle: a rule on the user, unchecked by the block.
`default_nettype none

module bresenham_line_pixel_stepper (
   input  logic      clock,
   input  logic      reset,
   bls_req_if.sink   req_ch,
   bls_rsp_if.source rsp_ch,
   bls_csr_if.sink   csr_ch
);
   import bls_pkg::*;

   bls_cfg_type   cfg_ff, cfg_in;
   logic          push, pop, full, empty;
   bls_pixel_type push_data, pop_data;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BITS_PER_PIXEL: cfg_in.bits_per_pixel = csr_ch.data[BPP_W-1:0];
            CSR_LINE_STRIDE:    cfg_in.line_stride    = csr_ch.data[STRIDE_W-1:0];
            CSR_WINDOW_WIDTH:   cfg_in.window_width   = csr_ch.data[WIN_W-1:0];
            CSR_WINDOW_HEIGHT:  cfg_in.window_height  = csr_ch.data[WIN_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bits_per_pixel <= RESET_BITS_PER_PIXEL;
         cfg_ff.line_stride    <= RESET_LINE_STRIDE;
         cfg_ff.window_width   <= RESET_WINDOW_WIDTH;
         cfg_ff.window_height  <= RESET_WINDOW_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   bls_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   bls_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .empty    (empty),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire
